// ===== sv/clock_cache_busy_pinned_top_defines.svh =====
// Assertion macros shared by the clock cache directory.
// Used by the top level only; needs clk and rst in scope.
`ifndef CLOCK_CACHE_BUSY_PINNED_TOP_DEFINES_SVH
`define CLOCK_CACHE_BUSY_PINNED_TOP_DEFINES_SVH

// same-cycle implication
`define CCBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccbp assertion failed");

// next-cycle implication
`define CCBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccbp assertion failed");

`endif

// ===== sv/ccbp_pkg.sv =====
// Types, codes and sizes for the clock cache directory.
// No dependencies.
package ccbp_pkg;
  localparam int SLOTS = 64;
  localparam int KEY_BITS = 32;
  localparam int KEY_W = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int BYTES_W = 24;
  localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 24'd1048576;
  localparam logic [6:0] ACTIVE_RESET = 7'd64;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [2:0] ST_MISS = 3'd0;
  localparam logic [2:0] ST_HIT = 3'd1;
  localparam logic [2:0] ST_STORED = 3'd2;
  localparam logic [2:0] ST_REJECT = 3'd3;
  localparam logic [2:0] ST_CACHED = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [1:0] REG_MAX_BYTES = 2'd0;
  localparam logic [1:0] REG_ACTIVE = 2'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [31:0] key_hash;
    logic [2:0] edit_threshold;
    logic [BYTES_W-1:0] entry_bytes;
    logic [5:0] release_slot;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [2:0] thr;
    logic [BYTES_W-1:0] size;
  } rec_t;
endpackage

// ===== sv/ccbp_req_if.sv =====
// Request channel of the clock cache directory.
// Depends on ccbp_pkg.
interface ccbp_req_if import ccbp_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [31:0] key_hash;
  logic [2:0] edit_threshold;
  logic [BYTES_W-1:0] entry_bytes;
  logic [5:0] release_slot;
  modport source (output valid, opcode, key_hash, edit_threshold, entry_bytes,
                  release_slot, input ready);
  modport sink (input valid, opcode, key_hash, edit_threshold, entry_bytes,
                release_slot, output ready);
endinterface

// ===== sv/ccbp_rsp_if.sv =====
// Result channel of the clock cache directory.
// No dependencies.
interface ccbp_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [5:0] slot;
  modport source (output valid, status, slot, input ready);
  modport sink (input valid, status, slot, output ready);
endinterface

// ===== sv/ccbp_cfg_if.sv =====
// Register write channel of the clock cache directory.
// Depends on ccbp_pkg.
interface ccbp_cfg_if import ccbp_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [BYTES_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ccbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== sv/ccbp_ctrl.sv =====
// Sequencer of the clock cache directory: key walk, clock sweep, evict, store, release, clear.
// Depends on ccbp_pkg; drives the record RAM ports.
module ccbp_ctrl import ccbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  input  logic [BYTES_W-1:0] max_bytes,
  input  logic [CNT_W-1:0] live,
  output logic idle,
  output logic res_valid,
  input  logic res_take,
  output res_t res,
  output logic ram_we,
  output logic [SLOT_W-1:0] ram_wr_addr,
  output rec_t ram_wr_data,
  output logic [SLOT_W-1:0] ram_rd_addr,
  input  rec_t ram_rd_data
);
  typedef enum logic [2:0] {
    S_IDLE, S_ADDR, S_CMP, S_SWEEP, S_EVRD, S_STORE, S_DONE
  } state_t;

  state_t state;
  req_t cur;
  logic [CNT_W-1:0] idx;
  logic [SLOT_W-1:0] arm;
  logic [SLOT_W-1:0] tgt;
  logic swept;
  logic [BYTES_W-1:0] used_bytes;
  logic [SLOTS-1:0] valid_q;
  logic [SLOTS-1:0] busy_q;
  logic [SLOTS-1:0] nr_q;

  logic [SLOT_W-1:0] idx_s;
  logic [SLOT_W-1:0] arm_inc;
  logic [SLOT_W-1:0] tgt_inc;
  logic fits;
  logic key_eq;

  assign idx_s = idx[SLOT_W-1:0];
  assign arm_inc = ({1'b0, arm} + 1'b1 >= (SLOT_W+1)'(live)) ? '0 : arm + 1'b1;
  assign tgt_inc = ({1'b0, tgt} + 1'b1 >= (SLOT_W+1)'(live)) ? '0 : tgt + 1'b1;
  assign fits = (used_bytes < max_bytes) && (cur.entry_bytes < max_bytes - used_bytes);
  assign key_eq = ram_rd_data.key == cur.key_hash[KEY_W-1:0];
  assign idle = state == S_IDLE;
  assign res_valid = state == S_DONE;
  assign ram_rd_addr = (state == S_SWEEP) ? arm : idx_s;
  assign ram_we = (state == S_STORE) && !valid_q[tgt] && fits;
  assign ram_wr_addr = tgt;
  assign ram_wr_data = '{key: cur.key_hash[KEY_W-1:0], thr: cur.edit_threshold,
                         size: cur.entry_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      arm <= '0;
      tgt <= '0;
      swept <= 1'b0;
      used_bytes <= '0;
      valid_q <= '0;
      busy_q <= '0;
      nr_q <= '1;
      res <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur <= req;
            idx <= '0;
            swept <= 1'b0;
            unique case (req.opcode)
              OP_LOOKUP, OP_INSERT: begin
                res <= '0;
                state <= S_ADDR;
              end
              OP_RELEASE: begin
                if (int'(req.release_slot) < SLOTS) begin
                  busy_q[req.release_slot[SLOT_W-1:0]] <= 1'b0;
                end
                res <= '{status: ST_DONE, slot: 6'd0};
                state <= S_DONE;
              end
              default: begin
                valid_q <= '0;
                busy_q <= '0;
                nr_q <= '1;
                arm <= '0;
                used_bytes <= '0;
                res <= '{status: ST_DONE, slot: 6'd0};
                state <= S_DONE;
              end
            endcase
          end
        end
        S_ADDR: begin
          if (idx >= live) begin
            if (cur.opcode == OP_LOOKUP) begin
              res.status <= ST_MISS;
              state <= S_DONE;
            end else begin
              swept <= 1'b1;
              if ({1'b0, arm} >= (SLOT_W+1)'(live)) arm <= '0;
              state <= S_SWEEP;
            end
          end else if (!valid_q[idx_s]) begin
            idx <= idx + 1'b1;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (!key_eq) begin
            idx <= idx + 1'b1;
            state <= S_ADDR;
          end else if (cur.opcode == OP_LOOKUP) begin
            if (!busy_q[idx_s] && ram_rd_data.thr >= cur.edit_threshold) begin
              nr_q[idx_s] <= 1'b0;
              busy_q[idx_s] <= 1'b1;
              res <= '{status: ST_HIT, slot: 6'(idx_s)};
            end else begin
              res.status <= ST_MISS;
            end
            state <= S_DONE;
          end else if (ram_rd_data.thr > cur.edit_threshold) begin
            res.status <= ST_CACHED;
            state <= S_DONE;
          end else if (busy_q[idx_s]) begin
            res.status <= ST_REJECT;
            state <= S_DONE;
          end else begin
            // evict in place, then try the store
            used_bytes <= (used_bytes >= ram_rd_data.size) ?
                          used_bytes - ram_rd_data.size : '0;
            valid_q[idx_s] <= 1'b0;
            nr_q[idx_s] <= 1'b1;
            tgt <= idx_s;
            state <= S_STORE;
          end
        end
        S_SWEEP: begin
          if (valid_q[arm] && !nr_q[arm] && busy_q[arm]) begin
            nr_q[arm] <= 1'b1;
            arm <= arm_inc;
          end else begin
            tgt <= arm;
            state <= (valid_q[arm] && !busy_q[arm]) ? S_EVRD : S_STORE;
          end
        end
        S_EVRD: begin
          used_bytes <= (used_bytes >= ram_rd_data.size) ?
                        used_bytes - ram_rd_data.size : '0;
          valid_q[tgt] <= 1'b0;
          nr_q[tgt] <= 1'b1;
          state <= S_STORE;
        end
        S_STORE: begin
          if (!valid_q[tgt] && fits) begin
            valid_q[tgt] <= 1'b1;
            busy_q[tgt] <= 1'b1;
            nr_q[tgt] <= 1'b0;
            used_bytes <= used_bytes + cur.entry_bytes;
            if (swept) arm <= tgt_inc;
            res <= '{status: ST_STORED, slot: 6'(tgt)};
          end else begin
            res.status <= ST_REJECT;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/clock_cache_busy_pinned_top.sv =====
// Clock cache directory with busy pinning and a byte budget. One request is
// worked at a time: a lookup or insert walks the slots one after another
// through the single record RAM read port, comparing the key of each valid
// slot and skipping empty ones; an insert that misses then sweeps the clock
// arm one slot per cycle, evicts the slot it stops on if valid and not
// busy, and tries the store. Release and clear go straight to the result.
// The result sits in an output register, so the next request is taken as
// soon as the sequencer is back in idle. Register writes are always ready.
// Depends on ccbp_pkg, the channel interfaces, ccbp_ram and ccbp_ctrl.
`include "clock_cache_busy_pinned_top_defines.svh"
module clock_cache_busy_pinned_top import ccbp_pkg::*; (
  input logic clk,
  input logic rst,
  ccbp_req_if.sink req,
  ccbp_rsp_if.source rsp,
  ccbp_cfg_if.sink cfg
);
  logic [BYTES_W-1:0] max_bytes;
  logic [6:0] active_slots;
  logic [CNT_W-1:0] live;
  logic idle;
  logic res_valid;
  logic res_take;
  res_t res;
  res_t out_q;
  logic out_valid;
  logic ram_we;
  logic [SLOT_W-1:0] ram_wr_addr;
  logic [SLOT_W-1:0] ram_rd_addr;
  rec_t ram_wr_data;
  rec_t ram_rd_data;
  req_t req_in;

  assign cfg.ready = 1'b1;
  assign req.ready = idle;
  assign req_in = '{opcode: req.opcode, key_hash: req.key_hash,
                    edit_threshold: req.edit_threshold,
                    entry_bytes: req.entry_bytes, release_slot: req.release_slot};
  assign live = (active_slots == '0) ? CNT_W'(1) :
                (int'(active_slots) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(active_slots);
  assign res_take = res_valid && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.status = out_q.status;
  assign rsp.slot = out_q.slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
      active_slots <= ACTIVE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_MAX_BYTES: max_bytes <= cfg.data;
          REG_ACTIVE: active_slots <= cfg.data[6:0];
          default: ;
        endcase
      end
      if (res_take) begin
        out_valid <= 1'b1;
        out_q <= res;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  ccbp_ram #(.WIDTH($bits(rec_t)), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .wr_addr(ram_wr_addr), .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr), .rd_data(ram_rd_data)
  );

  ccbp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(req.valid && idle), .req(req_in),
    .max_bytes(max_bytes), .live(live), .idle(idle), .res_valid(res_valid),
    .res_take(res_take), .res(res), .ram_we(ram_we), .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data), .ram_rd_addr(ram_rd_addr), .ram_rd_data(ram_rd_data)
  );

  `CCBP_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready)
  `CCBP_ASSERT_NOW(a_status_range, rsp.valid, rsp.status <= ST_DONE)
  `CCBP_ASSERT_NOW(a_slot_zero, rsp.valid && rsp.status != ST_HIT && rsp.status != ST_STORED,
                   rsp.slot == '0)
endmodule
